// ===== rtl/v4mt_pkg.sv =====
package v4mt_pkg;

    localparam int DATA_BITS = 32;

    // request function codes
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_ROW   = 2'd1;
    localparam logic [1:0] FUNC_COL   = 2'd2;

    typedef struct packed {
        logic [1:0]                  func;
        logic [1:0]                  elem_row;
        logic [1:0]                  elem_col;
        logic signed [DATA_BITS-1:0] elem_value;
        logic signed [DATA_BITS-1:0] vec_x;
        logic signed [DATA_BITS-1:0] vec_y;
        logic signed [DATA_BITS-1:0] vec_z;
        logic signed [DATA_BITS-1:0] vec_w;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_BITS-1:0] res_x;
        logic signed [DATA_BITS-1:0] res_y;
        logic signed [DATA_BITS-1:0] res_z;
        logic signed [DATA_BITS-1:0] res_w;
        logic                        saturated;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_ROW,
        OP_COL
    } op_t;

    // Classified command passed from front to back.
    // A write carries its value in word[0]; a transform carries x, y, z, w.
    typedef struct packed {
        op_t                             op;
        logic [3:0]                      addr;
        logic [3:0][DATA_BITS-1:0]       word;
    } cmd_t;

endpackage

// ===== rtl/v4mt_queue.sv =====
module v4mt_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = store_reg[rd_ptr_reg];

endmodule

// ===== rtl/v4mt_front.sv =====
module v4mt_front
    import v4mt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    output logic     cmd_valid,
    input  logic     cmd_ready,
    output cmd_t     cmd
);

    cmd_t             cmd_in;
    logic             keep;
    logic             full;
    logic             empty;
    logic [$bits(cmd_t)-1:0] pop_data;

    // classify; drop the unused function code
    always_comb begin
        cmd_in      = '0;
        cmd_in.addr = {s_item.elem_row, s_item.elem_col};
        keep        = 1'b1;
        case (s_item.func)
            FUNC_WRITE: begin
                cmd_in.op      = OP_WRITE;
                cmd_in.word[0] = s_item.elem_value;
            end
            FUNC_ROW, FUNC_COL: begin
                cmd_in.op      = (s_item.func == FUNC_ROW) ? OP_ROW : OP_COL;
                cmd_in.word[0] = s_item.vec_x;
                cmd_in.word[1] = s_item.vec_y;
                cmd_in.word[2] = s_item.vec_z;
                cmd_in.word[3] = s_item.vec_w;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_ready = !full;

    v4mt_queue #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid && s_ready && keep),
        .push_data (cmd_in),
        .full      (full),
        .pop       (cmd_valid && cmd_ready),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    assign cmd_valid = !empty;
    assign cmd       = cmd_t'(pop_data);

endmodule

// ===== rtl/v4mt_back.sv =====
module v4mt_back
    import v4mt_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_t      cmd,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int PROD_W = 2 * WORD_BITS;
    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam logic signed [WORD_BITS-1:0] MAX_W = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] MIN_W = {1'b1, {(WORD_BITS-1){1'b0}}};

    logic signed [WORD_BITS-1:0] matrix_reg [16];
    logic signed [PROD_W-1:0]    prod_reg [4][4];
    logic signed [PAIR_W-1:0]    pair_reg [4][2];
    logic                        s1_valid_reg, s2_valid_reg, out_valid_reg;
    out_item_t                   out_reg;

    logic signed [WORD_BITS-1:0] vec [4];
    logic signed [WORD_BITS-1:0] coef [4][4];
    logic signed [SUM_W-1:0]     sum [4];
    logic signed [SUM_W-1:0]     shifted [4];
    logic signed [WORD_BITS-1:0] clip [4];
    logic [3:0]                  over;
    logic                        is_write;
    logic                        ready1, ready2, ready3;

    assign is_write  = (cmd.op == OP_WRITE);
    assign ready3    = !out_valid_reg || m_ready;
    assign ready2    = !s2_valid_reg || ready3;
    assign ready1    = !s1_valid_reg || ready2;
    assign cmd_ready = is_write ? 1'b1 : ready1;

    // pick row-mode or column-mode coefficients
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            vec[j] = signed'(cmd.word[j][WORD_BITS-1:0]);
        end
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                coef[i][j] = (cmd.op == OP_ROW) ? matrix_reg[i*4 + j]
                                                : matrix_reg[j*4 + i];
            end
        end
    end

    // final add, floor shift, saturate
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            sum[i]     = SUM_W'(pair_reg[i][0]) + SUM_W'(pair_reg[i][1]);
            shifted[i] = sum[i] >>> FRAC_BITS;
            over[i]    = !((&shifted[i][SUM_W-1:WORD_BITS-1]) ||
                           !(|shifted[i][SUM_W-1:WORD_BITS-1]));
            if (!over[i]) begin
                clip[i] = shifted[i][WORD_BITS-1:0];
            end else begin
                clip[i] = shifted[i][SUM_W-1] ? MIN_W : MAX_W;
            end
        end
    end

    // control and matrix state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 16; k++) begin
                matrix_reg[k] <= '0;
            end
        end else begin
            if (cmd_valid && is_write) begin
                matrix_reg[cmd.addr] <= signed'(cmd.word[0][WORD_BITS-1:0]);
            end
            if (ready1) begin
                s1_valid_reg <= cmd_valid && !is_write;
            end
            if (ready2) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ready3) begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (ready1 && cmd_valid && !is_write) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    prod_reg[i][j] <= PROD_W'(vec[j]) * PROD_W'(coef[i][j]);
                end
            end
        end
        if (ready2 && s1_valid_reg) begin
            for (int i = 0; i < 4; i++) begin
                for (int k = 0; k < 2; k++) begin
                    pair_reg[i][k] <= PAIR_W'(prod_reg[i][2*k])
                                    + PAIR_W'(prod_reg[i][2*k + 1]);
                end
            end
        end
        if (ready3 && s2_valid_reg) begin
            out_reg.res_x     <= DATA_BITS'(clip[0]);
            out_reg.res_y     <= DATA_BITS'(clip[1]);
            out_reg.res_z     <= DATA_BITS'(clip[2]);
            out_reg.res_w     <= DATA_BITS'(clip[3]);
            out_reg.saturated <= |over;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

endmodule

// ===== rtl/vec4_matrix_transform_unit.sv =====
// A transform result passes the queue, then the product, pair-sum and output registers.
// Throughput: one request per cycle unless m_ready stalls; 16 multipliers, fully pipelined.
// Matrix writes and unused function codes produce no result; only writes take a queue slot.
// Reset (aresetn low, synchronous): matrix clears to zero, queue and pipeline empty.
// Stalls on m_ready back up through the pipeline into the QUEUE_DEPTH-entry queue.
module vec4_matrix_transform_unit
    import v4mt_pkg::*;
#(
    parameter int WORD_BITS   = 32,
    parameter int FRAC_BITS   = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    // Front to back command stream. The queue between them lets the
    // input side keep taking requests while the result side is stalled.
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    // Front: classify each request (write, row transform, column
    // transform), drop the unused code, and queue the rest in order.
    v4mt_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // Back: holds the matrix. Writes update it in queue order, so a
    // transform always sees exactly the writes that came before it.
    // Transforms run multiply, pair add, final add with floor shift and
    // saturation, then land in the output register.
    v4mt_back #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import v4mt_pkg::*;

    localparam int WORD_BITS   = 32;
    localparam int FRAC_BITS   = 16;
    localparam int RANDOM_REQS = 750;
    localparam int HOLD_CYCLES = 120;
    localparam int DRAIN_WAIT  = 8;
    localparam int CYCLE_LIMIT = 200000;

    // func code 3 is not decoded by the block: no matrix update, no result
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [31:0] Q_ONE  = 32'h0001_0000;
    localparam logic [31:0] Q_HALF = 32'hFFFF_8000;   // -0.5
    localparam logic [31:0] W_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] W_MIN  = 32'h8000_0000;
    localparam logic [31:0] W_ONES = 32'hFFFF_FFFF;

    localparam logic signed [67:0] SUM_MAX = 68'sd2147483647;
    localparam logic signed [67:0] SUM_MIN = -68'sd2147483648;

    // One stimulus row: the request, plus an expected vertex when it is
    // obvious enough to type in by hand.
    typedef struct {
        in_item_t  req;
        bit        typed;
        out_item_t want;
    } stim_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    // Local copy of the coefficient matrix, element (row, col) at row*4+col
    logic signed [31:0] model_matrix [16];

    stim_row_t directed_rows[$];
    stim_row_t sent_rows[$];          // requests offered, in order, awaiting acceptance
    out_item_t expected_vertices[$];  // transform results still owed by the block

    int mismatches = 0;
    bit src_burst  = 1'b0;
    bit snk_burst  = 1'b0;
    bit hold_req   = 1'b0;

    vec4_matrix_transform_unit #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor: exact 4-term dot products, floor shift, saturate to 32 bits
    // ------------------------------------------------------------------
    function automatic out_item_t transform_vertex(input in_item_t req);
        logic signed [31:0] vec [4];
        logic signed [31:0] comp [4];
        logic signed [67:0] a;
        logic signed [67:0] b;
        logic signed [67:0] acc;
        logic signed [67:0] shifted;
        logic               clipped;
        out_item_t          res;
        int                 i;
        int                 j;
        vec[0]  = req.vec_x;
        vec[1]  = req.vec_y;
        vec[2]  = req.vec_z;
        vec[3]  = req.vec_w;
        clipped = 1'b0;
        for (i = 0; i < 4; i++) begin
            acc = '0;
            for (j = 0; j < 4; j++) begin
                a = vec[j];
                // row mode walks row i of the matrix, column mode walks column i
                b = (req.func == FUNC_ROW) ? model_matrix[i*4 + j] : model_matrix[j*4 + i];
                acc = acc + a * b;
            end
            shifted = acc >>> FRAC_BITS;
            if (shifted > SUM_MAX) begin
                shifted = SUM_MAX;
                clipped = 1'b1;
            end else if (shifted < SUM_MIN) begin
                shifted = SUM_MIN;
                clipped = 1'b1;
            end
            comp[i] = shifted[31:0];
        end
        res.res_x     = comp[0];
        res.res_y     = comp[1];
        res.res_z     = comp[2];
        res.res_w     = comp[3];
        res.saturated = clipped;
        return res;
    endfunction

    function automatic in_item_t make_request(input logic [1:0] func, input logic [1:0] row,
                                              input logic [1:0] col, input logic [31:0] value,
                                              input logic [31:0] x, input logic [31:0] y,
                                              input logic [31:0] z, input logic [31:0] w);
        in_item_t req;
        req.func       = func;
        req.elem_row   = row;
        req.elem_col   = col;
        req.elem_value = value;
        req.vec_x      = x;
        req.vec_y      = y;
        req.vec_z      = z;
        req.vec_w      = w;
        return req;
    endfunction

    function automatic out_item_t make_vertex(input logic [31:0] x, input logic [31:0] y,
                                              input logic [31:0] z, input logic [31:0] w,
                                              input logic sat);
        out_item_t res;
        res.res_x     = x;
        res.res_y     = y;
        res.res_z     = z;
        res.res_w     = w;
        res.saturated = sat;
        return res;
    endfunction

    task automatic add_row(input in_item_t req, input bit typed, input out_item_t want);
        stim_row_t row;
        row.req   = req;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // Mix full-range words, small Q16.16 values (about +/-8.0) and corner words
    function automatic logic [31:0] random_word();
        logic [31:0] w;
        case ($urandom_range(0, 4))
            0, 1: w = $urandom;
            2, 3: w = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            default: begin
                case ($urandom_range(0, 5))
                    0: w = W_MAX;
                    1: w = W_MIN;
                    2: w = W_ONES;
                    3: w = Q_ONE;
                    4: w = 32'd1;
                    default: w = '0;
                endcase
            end
        endcase
        return w;
    endfunction

    function automatic in_item_t random_request();
        in_item_t req;
        int       pick;
        req  = make_request(FUNC_WRITE, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                            random_word(), random_word(), random_word(),
                            random_word(), random_word());
        pick = $urandom_range(0, 19);
        // Keep matrix writes frequent enough that transforms see fresh coefficients
        if (pick < 5)
            req.func = FUNC_WRITE;
        else if (pick < 12)
            req.func = FUNC_ROW;
        else if (pick < 19)
            req.func = FUNC_COL;
        else
            req.func = FUNC_UNUSED;
        return req;
    endfunction

    task automatic check_word(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch: expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_vertex(input out_item_t got);
        out_item_t want;
        if (expected_vertices.size() == 0) begin
            $display("%0t ns: unexpected result: expected none, got %h", $time, got);
            mismatches++;
        end else begin
            want = expected_vertices.pop_front();
            check_word("res_x", want.res_x, got.res_x);
            check_word("res_y", want.res_y, got.res_y);
            check_word("res_z", want.res_z, got.res_z);
            check_word("res_w", want.res_w, got.res_w);
            if (got.saturated !== want.saturated) begin
                $display("%0t ns: saturated mismatch: expected %b, got %b",
                         $time, want.saturated, got.saturated);
                mismatches++;
            end
        end
    endtask

    // Offer one request: idle for a drawn gap, raise valid, hold until accepted.
    // Return right after the accepting rising edge.
    task automatic send_request(input stim_row_t row);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 4);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        sent_rows.push_back(row);
        s_item  <= row.req;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    // ------------------------------------------------------------------
    // Monitor: update the local matrix and predict on every accepted
    // request, then compare every accepted result against the oldest
    // expectation. Predict first so a result seen at its request's edge would still line up.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        stim_row_t row;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                row = sent_rows.pop_front();
                if (s_item.func == FUNC_WRITE)
                    model_matrix[{s_item.elem_row, s_item.elem_col}] = s_item.elem_value;
                else if (s_item.func != FUNC_UNUSED)
                    expected_vertices.push_back(row.typed ? row.want : transform_vertex(s_item));
            end
            if (m_valid && m_ready)
                check_vertex(m_item);
        end
    end

    // ------------------------------------------------------------------
    // Result sink: stall a drawn number of cycles before each result, or
    // hold off for a long stretch when asked, so the queue fills and
    // s_ready drops while the source keeps offering.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                for (stall = 0; stall < HOLD_CYCLES; stall++)
                    @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                stall = snk_burst ? 0 : $urandom_range(0, 4);
                if (stall != 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(negedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Watchdog: give up well past the slowest legal run
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        stim_row_t row;
        out_item_t none;
        int        n;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item  = '0;
        none    = '0;
        for (n = 0; n < 16; n++)
            model_matrix[n] = '0;

        // Matrix is all zero after reset, so any transform gives zero
        add_row(make_request(FUNC_ROW, 2'd3, 2'd3, W_ONES, W_MAX, W_MIN, W_ONES, 32'd1),
                1'b1, make_vertex('0, '0, '0, '0, 1'b0));
        add_row(make_request(FUNC_COL, 2'd3, 2'd3, W_ONES, W_MAX, W_MIN, W_ONES, 32'd1),
                1'b1, make_vertex('0, '0, '0, '0, 1'b0));
        // Unused code: nothing happens
        add_row(make_request(FUNC_UNUSED, 2'd3, 2'd3, W_ONES, W_ONES, W_ONES, W_ONES, W_ONES),
                1'b0, none);
        // Load identity; vector fields on writes are don't-care
        for (n = 0; n < 4; n++)
            add_row(make_request(FUNC_WRITE, 2'(n), 2'(n), Q_ONE, W_ONES, W_MIN, W_MAX, W_ONES),
                    1'b0, none);
        // Identity passes the vector through exactly, extremes included
        add_row(make_request(FUNC_ROW, 2'd2, 2'd1, W_MAX, 32'h0003_0000, Q_HALF, W_MAX, W_MIN),
                1'b1, make_vertex(32'h0003_0000, Q_HALF, W_MAX, W_MIN, 1'b0));
        add_row(make_request(FUNC_COL, 2'd1, 2'd2, W_MIN, 32'h0003_0000, Q_HALF, W_MAX, W_MIN),
                1'b1, make_vertex(32'h0003_0000, Q_HALF, W_MAX, W_MIN, 1'b0));
        // Most negative coefficient: min*min clips high, min*max clips low
        add_row(make_request(FUNC_WRITE, 2'd0, 2'd0, W_MIN, '0, '0, '0, '0), 1'b0, none);
        add_row(make_request(FUNC_ROW, 2'd0, 2'd0, '0, W_MIN, 32'd5, 32'd6, 32'd7),
                1'b1, make_vertex(W_MAX, 32'd5, 32'd6, 32'd7, 1'b1));
        add_row(make_request(FUNC_ROW, 2'd0, 2'd0, '0, W_MAX, '0, '0, '0),
                1'b1, make_vertex(W_MIN, '0, '0, '0, 1'b1));
        // Asymmetric matrix: row and column mode must differ
        add_row(make_request(FUNC_WRITE, 2'd0, 2'd0, Q_ONE, W_ONES, W_ONES, W_ONES, W_ONES),
                1'b0, none);
        add_row(make_request(FUNC_WRITE, 2'd0, 2'd3, W_MAX, '0, '0, '0, '0), 1'b0, none);
        add_row(make_request(FUNC_WRITE, 2'd3, 2'd0, W_ONES, '0, '0, '0, '0), 1'b0, none);
        add_row(make_request(FUNC_WRITE, 2'd2, 2'd1, Q_HALF, '0, '0, '0, '0), 1'b0, none);
        // Small negative terms exercise the floor on the shift
        add_row(make_request(FUNC_ROW, 2'd1, 2'd1, W_ONES, -32'sd3, 32'd7, W_ONES, 32'h0003_0000),
                1'b0, none);
        add_row(make_request(FUNC_COL, 2'd1, 2'd1, W_ONES, -32'sd3, 32'd7, W_ONES, 32'h0003_0000),
                1'b0, none);
        add_row(make_request(FUNC_UNUSED, '0, '0, '0, '0, '0, '0, '0), 1'b0, none);
        add_row(make_request(FUNC_WRITE, 2'd1, 2'd2, W_MAX, '0, '0, '0, '0), 1'b0, none);
        add_row(make_request(FUNC_WRITE, 2'd3, 2'd3, W_MIN, '0, '0, '0, '0), 1'b0, none);
        // Full-scale vectors against a mixed matrix
        add_row(make_request(FUNC_ROW, '0, '0, '0, W_MIN, W_MIN, W_MIN, W_MIN), 1'b0, none);
        add_row(make_request(FUNC_COL, '0, '0, '0, W_MAX, W_MAX, W_MAX, W_MAX), 1'b0, none);

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Walk the directed table
        foreach (directed_rows[k])
            send_request(directed_rows[k]);

        // Random requests; switch idling style every 50 requests and
        // twice hold the sink off while the source runs flat out
        for (n = 0; n < RANDOM_REQS; n++) begin
            if (n % 50 == 0) begin
                src_burst = ($urandom_range(0, 3) == 0);
                snk_burst = ($urandom_range(0, 3) == 0);
            end
            if (n == 250 || n == 550) begin
                hold_req  = 1'b1;
                src_burst = 1'b1;
            end
            row.req   = random_request();
            row.typed = 1'b0;
            row.want  = none;
            send_request(row);
        end

        @(negedge aclk);
        s_valid <= 1'b0;

        // Drain, then allow a few more cycles for stray results
        while (expected_vertices.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/v4mt_pkg.sv
rtl/v4mt_queue.sv
rtl/v4mt_front.sv
rtl/v4mt_back.sv
rtl/vec4_matrix_transform_unit.sv
bench/tb.sv
